>>> hdl/wbmc_pkg.sv
// Package for the watch button and mode controller.
// Holds mode and action codes, timing constants and the types shared by the step logic
// and the top level. No dependencies.
`default_nettype none

package wbmc_pkg;

	localparam int unsigned HOLD_W  = 16;
	localparam int unsigned IDLE_W  = 24;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned ACT_W   = 2;

	localparam logic [HOLD_W-1:0] LONG_PRESS_RST   = 16'd1000;
	localparam logic [IDLE_W-1:0] INACTIVE_LIM_RST = 24'd10000;
	localparam logic [IDLE_W-1:0] TICK_MS          = 24'd5;

	localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADJUST = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIRED  = 2'd2;

	localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TIME   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_ALARM  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

	localparam logic TICK_FAST = 1'b0;
	localparam logic TICK_SLOW = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              armed;
		logic [HOLD_W-1:0] hold0;
		logic [HOLD_W-1:0] hold1;
		logic [IDLE_W-1:0] idle;
		logic              beep_phase;
		logic              beep_level;
	} state_t;

	typedef struct packed {
		logic       slow;
		logic [1:0] held;
		logic [1:0] pressed;
		logic [1:0] released;
		logic       motion;
		logic       aflag;
	} tick_t;

	typedef struct packed {
		logic [MODE_W-1:0] watch_mode;
		logic [ACT_W-1:0]  act0;
		logic [ACT_W-1:0]  act1;
		logic              alarm_on;
		logic              changed;
		logic              clear;
		logic              buzzer;
		logic              sleep;
	} result_t;

	typedef struct packed {
		logic [HOLD_W-1:0] long_press;
		logic [IDLE_W-1:0] idle_limit;
	} cfg_t;

endpackage

`default_nettype wire

>>> hdl/wbmc_step.sv
// Step logic of the watch button and mode controller: next state and result of one tick.
// Purely combinational; depends on wbmc_pkg.
`default_nettype none

module wbmc_step (
	input  wbmc_pkg::cfg_t    cfg,
	input  wbmc_pkg::state_t  cur,
	input  wbmc_pkg::tick_t   tick,
	output wbmc_pkg::state_t  nxt,
	output wbmc_pkg::result_t res
);
	import wbmc_pkg::*;

	logic [HOLD_W:0]   sum0;
	logic [HOLD_W:0]   sum1;
	logic [HOLD_W-1:0] sat0;
	logic [HOLD_W-1:0] sat1;
	logic [IDLE_W:0]   isum;
	logic [IDLE_W-1:0] isat;
	logic              lp0;
	logic              lp1;

	assign sum0 = {1'b0, cur.hold0} + {1'b0, TICK_MS[HOLD_W-1:0]};
	assign sum1 = {1'b0, cur.hold1} + {1'b0, TICK_MS[HOLD_W-1:0]};
	assign sat0 = sum0[HOLD_W] ? {HOLD_W{1'b1}} : sum0[HOLD_W-1:0];
	assign sat1 = sum1[HOLD_W] ? {HOLD_W{1'b1}} : sum1[HOLD_W-1:0];
	assign isum = {1'b0, cur.idle} + {1'b0, TICK_MS};
	assign isat = isum[IDLE_W] ? {IDLE_W{1'b1}} : isum[IDLE_W-1:0];
	assign lp0  = (sat0 == cfg.long_press) && (sat0 != cur.hold0);
	assign lp1  = (sat1 == cfg.long_press) && (sat1 != cur.hold1);

	always_comb begin
		nxt = cur;
		res = '0;
		if (tick.slow == TICK_FAST) begin
			if (tick.held[0]) begin
				nxt.hold0 = sat0;
				if (lp0) begin
					nxt.mode = (cur.mode == MODE_NORMAL) ? MODE_ADJUST : MODE_NORMAL;
				end
			end
			if (tick.held[1]) begin
				nxt.hold1 = sat1;
				if (lp1) begin
					nxt.armed   = ~cur.armed;
					res.changed = 1'b1;
				end
			end
			if (tick.held == 2'b00) begin
				nxt.idle = isat;
			end
			if ((tick.pressed != 2'b00) || tick.motion) begin
				nxt.idle = '0;
			end
			if (tick.released[0]) begin
				if (nxt.hold0 < cfg.long_press) begin
					case (nxt.mode)
						MODE_NORMAL: res.act0 = ACT_TIME;
						MODE_ADJUST: res.act0 = ACT_ALARM;
						MODE_FIRED: begin
							res.act0       = ACT_CLEAR;
							res.clear      = 1'b1;
							nxt.beep_level = 1'b0;
							nxt.mode       = MODE_NORMAL;
						end
						default: res.act0 = ACT_NONE;
					endcase
				end
				nxt.hold0 = '0;
			end
			if (tick.released[1]) begin
				if (nxt.hold1 < cfg.long_press) begin
					case (nxt.mode)
						MODE_NORMAL: res.act1 = ACT_TIME;
						MODE_ADJUST: res.act1 = ACT_ALARM;
						MODE_FIRED: begin
							res.act1       = ACT_CLEAR;
							res.clear      = 1'b1;
							nxt.beep_level = 1'b0;
							nxt.mode       = MODE_NORMAL;
						end
						default: res.act1 = ACT_NONE;
					endcase
				end
				nxt.hold1 = '0;
			end
		end else begin
			if (tick.aflag) begin
				if (cur.armed) begin
					nxt.mode = MODE_FIRED;
				end else begin
					res.clear = 1'b1;
				end
			end
			if (nxt.mode == MODE_FIRED) begin
				nxt.beep_level = cur.beep_phase;
				nxt.beep_phase = ~cur.beep_phase;
			end
			res.sleep = (cur.idle >= cfg.idle_limit) && (nxt.mode != MODE_FIRED);
		end
		res.watch_mode = nxt.mode;
		res.alarm_on   = nxt.armed;
		res.buzzer     = nxt.beep_level;
	end

endmodule

`default_nettype wire

>>> hdl/watch_button_mode_controller.sv
// Top level of the watch button and mode controller: tick register, state, result register
// and configuration registers. Depends on wbmc_pkg and wbmc_step.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one tick per transfer: mode selects a fast
//   5 ms tick or a slow one-second tick, with button levels and edges, motion and the
//   clock's alarm flag. Output channel (out_valid/out_stall) carries one result per tick:
//   mode, button actions, alarm enable, pulses and buzzer level.
//   Flow: the tick register loads at the input transfer; the step logic then fills the
//   result register, and out_valid rises, once that register is empty or not stalled.
//   Throughput is one tick per cycle while the receiver does not stall; the state
//   registers update in the same cycle the result register loads, so each tick sees
//   the state left by the one before.
//   When the receiver stalls, the result register holds and the tick register takes one
//   more tick; in_stall rises only when both are full.
//   Configuration: APB writes at byte 0 (long press time, 16 bits) and byte 4 (idle
//   limit, 24 bits); write only while no tick is in flight.
//   Reset clears the state register and the valids (not the tick and result registers),
//   and loads the default configuration (1000 ms long press, 10000 ms idle limit).
`default_nettype none

module watch_button_mode_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [1:0]  buttons_held,
	input  wire logic [1:0]  buttons_pressed,
	input  wire logic [1:0]  buttons_released,
	input  wire logic        motion_event,
	input  wire logic        alarm_flag,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [1:0]  watch_mode,
	output logic      [1:0]  button0_action,
	output logic      [1:0]  button1_action,
	output logic             alarm_on,
	output logic             alarm_enable_changed,
	output logic             clear_alarm,
	output logic             buzzer_on,
	output logic             sleep_request
);
	import wbmc_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    out_free;
	logic    advance;
	logic    in_xfer;
	logic    cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		case (paddr[2])
			1'b0:    prdata = {16'd0, cfg_q.long_press};
			default: prdata = {8'd0, cfg_q.idle_limit};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press <= LONG_PRESS_RST;
			cfg_q.idle_limit <= INACTIVE_LIM_RST;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				cfg_q.idle_limit <= pwdata[IDLE_W-1:0];
			end else begin
				cfg_q.long_press <= pwdata[HOLD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tick_s1 <= '{slow: mode, held: buttons_held, pressed: buttons_pressed,
				released: buttons_released, motion: motion_event, aflag: alarm_flag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	wbmc_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.tick (tick_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid            = valid_s2;
	assign watch_mode           = res_s2.watch_mode;
	assign button0_action       = res_s2.act0;
	assign button1_action       = res_s2.act1;
	assign alarm_on             = res_s2.alarm_on;
	assign alarm_enable_changed = res_s2.changed;
	assign clear_alarm          = res_s2.clear;
	assign buzzer_on            = res_s2.buzzer;
	assign sleep_request        = res_s2.sleep;

endmodule

`default_nettype wire
